@@ rtl/olce_pkg.sv @@
// shared types, command codes and status codes for the ordered char list engine
// no dependencies; imported by olce_cell, ordered_char_list_engine_core, olce_result_checker and testbench
package olce_pkg;

    // default list capacity
    localparam int DEPTH_DEFAULT = 16;

    // command codes of the input transaction
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;
    localparam logic [2:0] OP_DUMP       = 3'd5;

    // status codes of the result transaction
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // per-cycle commands broadcast to every cell of the chain
    localparam logic [2:0] CELL_HOLD       = 3'd0;
    localparam logic [2:0] CELL_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CELL_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CELL_POP_FRONT  = 3'd3;
    localparam logic [2:0] CELL_REMOVE     = 3'd4;
    localparam logic [2:0] CELL_ROTATE     = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] key_char;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_char;
        logic       last;
        logic [4:0] count;
    } out_item_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] key;
    } cell_ctrl_t;

endpackage

@@ rtl/olce_cell.sv @@
// one storage cell of the list chain: holds one character at a fixed position
// depends on olce_pkg for the cell command codes and control struct
module olce_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 5
) (
    input  logic                aclk,
    input  olce_pkg::cell_ctrl_t ctrl,
    input  logic [LEN_W-1:0]    len,
    input  logic [7:0]          left_data,
    input  logic [7:0]          right_data,
    input  logic [7:0]          head_data,
    input  logic                hit_in,
    output logic                hit_out,
    output logic [7:0]          data
);
    import olce_pkg::*;

    localparam logic [LEN_W-1:0] POS      = LEN_W'(INDEX);
    localparam logic [LEN_W-1:0] POS_NEXT = LEN_W'(INDEX + 1);

    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       in_list;
    logic       is_tail;
    logic       at_end;

    // position of this cell relative to the current list
    assign in_list = POS < len;
    assign is_tail = POS_NEXT == len;
    assign at_end  = POS == len;

    // first-match chain: set from the matching cell onward
    assign hit_out = hit_in | (in_list && (data_reg == ctrl.key));

    // next value of the stored character
    always_comb begin
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_PUSH_FRONT: data_next = left_data;
            CELL_PUSH_BACK: begin
                if (at_end) data_next = ctrl.key;
            end
            CELL_POP_FRONT: data_next = right_data;
            CELL_REMOVE: begin
                if (hit_out) data_next = right_data;
            end
            CELL_ROTATE: begin
                if (is_tail) begin
                    data_next = head_data;
                end else if (in_list) begin
                    data_next = right_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

@@ rtl/ordered_char_list_engine_core.sv @@
// top level of the ordered char list engine: control, length and result register
// depends on olce_pkg and instantiates a chain of DEPTH olce_cell instances
//
//  channel | ports                     | payload
//  --------+---------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data  | in_item_t  {op, key_char}
//  result  | m_valid, m_ready, m_data  | out_item_t {status, out_char, last, count}
//
// an edit command updates the cell chain and registers its result at the same
// clock edge; a dump gives no result in its accept cycle, then one element per
// cycle while the result register is free or being drained, rotating the chain
// once per emitted element so the list is back in place after the last one.
// aresetn is synchronous, active low, and empties the list (cell contents stay).
// a stalled result holds the chain; a new transaction is taken once the result
// register is free or being drained and no dump is in progress.
module ordered_char_list_engine_core #(
    parameter int DEPTH = olce_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  olce_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output olce_pkg::out_item_t m_data
);
    import olce_pkg::*;

    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic             state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] dump_cnt_reg, dump_cnt_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg, out_next;

    cell_ctrl_t       ctrl;
    logic [7:0]       cell_data [DEPTH];
    logic [DEPTH:0]   hit;
    logic             out_free;
    logic             accept;
    logic             full;
    logic             empty;
    logic             dump_last;
    logic [LEN_W+4:0] len_wide;

    // cell chain
    assign hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [7:0] left_d;
        logic [7:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = ctrl.key;
        end else begin : g_mid
            assign left_d = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_lastc
            assign right_d = cell_data[g];
        end else begin : g_inner
            assign right_d = cell_data[g+1];
        end
        olce_cell #(
            .INDEX(g),
            .LEN_W(LEN_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .len       (len_reg),
            .left_data (left_d),
            .right_data(right_d),
            .head_data (cell_data[0]),
            .hit_in    (hit[g]),
            .hit_out   (hit[g+1]),
            .data      (cell_data[g])
        );
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign full     = len_reg == LEN_FULL;
    assign empty    = len_reg == '0;
    assign dump_last = (dump_cnt_reg + LEN_ONE) == len_reg;

    // count field carries the low five bits of the new length
    assign len_wide = (LEN_W + 5)'(len_next);

    // command decode and result build
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        dump_cnt_next = dump_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ctrl.cmd      = CELL_HOLD;
        ctrl.key      = s_data.key_char;
        out_next      = out_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    out_next.status   = ST_OK;
                    out_next.out_char = 8'd0;
                    out_next.last     = 1'b1;
                    m_valid_next      = 1'b1;
                    case (s_data.op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (full) begin
                                out_next.status = ST_FULL;
                            end else begin
                                ctrl.cmd = (s_data.op == OP_PUSH_FRONT) ?
                                           CELL_PUSH_FRONT : CELL_PUSH_BACK;
                                len_next = len_reg + LEN_ONE;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) begin
                                out_next.status = ST_EMPTY;
                            end else begin
                                if (s_data.op == OP_POP_FRONT) ctrl.cmd = CELL_POP_FRONT;
                                len_next = len_reg - LEN_ONE;
                            end
                        end
                        OP_REMOVE: begin
                            ctrl.cmd = CELL_REMOVE;
                            if (hit[DEPTH]) begin
                                len_next = len_reg - LEN_ONE;
                            end else begin
                                out_next.status = ST_NOTFOUND;
                            end
                        end
                        OP_DUMP: begin
                            if (empty) begin
                                out_next.status = ST_EMPTY;
                            end else begin
                                m_valid_next  = 1'b0;
                                state_next    = S_DUMP;
                                dump_cnt_next = '0;
                            end
                        end
                        default: out_next.status = ST_OK;
                    endcase
                    out_next.count = len_wide[4:0];
                end
            end
            S_DUMP: begin
                // once the result register is free, emit the head and rotate the list by one
                if (out_free) begin
                    ctrl.cmd          = CELL_ROTATE;
                    out_next.status   = ST_OK;
                    out_next.out_char = cell_data[0];
                    out_next.last     = dump_last;
                    out_next.count    = len_wide[4:0];
                    m_valid_next      = 1'b1;
                    dump_cnt_next     = dump_cnt_reg + LEN_ONE;
                    if (dump_last) state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            dump_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            dump_cnt_reg <= dump_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ tb/olce_result_checker.sv @@
// checker for the ordered char list engine: mirrors the list, predicts and compares results
// depends on olce_pkg; watches the input and result channels of ordered_char_list_engine_core
module olce_result_checker #(
    parameter int DEPTH = olce_pkg::DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  olce_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  olce_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);
    import olce_pkg::*;

    // mirror of the list, front at index 0
    logic [7:0]  chars [DEPTH];
    int unsigned used;

    // results still owed by the block, oldest first
    out_item_t   owed_results [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        used       = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < 30) begin
            $display("mismatch on result %0d: %s", checked, what);
        end
        fail_count++;
    endtask

    // close the gap left by the element at pos
    task automatic drop_char(input int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < used; i++) begin
            chars[i] = chars[i + 1];
        end
        used--;
    endtask

    // work out the results of one accepted command and update the mirror
    task automatic apply_command(input in_item_t cmd);
        out_item_t   res;
        int unsigned i;
        bit          hit;
        res.status   = ST_OK;
        res.out_char = 8'd0;
        res.last     = 1'b1;
        hit          = 1'b0;
        case (cmd.op)
            OP_PUSH_FRONT: begin
                if (used >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = used; i > 0; i--) begin
                        chars[i] = chars[i - 1];
                    end
                    chars[0] = cmd.key_char;
                    used++;
                end
            end
            OP_PUSH_BACK: begin
                if (used >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    chars[used] = cmd.key_char;
                    used++;
                end
            end
            OP_POP_FRONT: begin
                if (used == 0) res.status = ST_EMPTY;
                else drop_char(0);
            end
            OP_POP_BACK: begin
                if (used == 0) res.status = ST_EMPTY;
                else used--;
            end
            OP_REMOVE: begin
                // first match from the front only
                for (i = 0; i < used && !hit; i++) begin
                    if (chars[i] == cmd.key_char) begin
                        drop_char(i);
                        hit = 1'b1;
                    end
                end
                if (!hit) res.status = ST_NOTFOUND;
            end
            OP_DUMP: begin
                if (used == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // one result per element, front to back, final one flagged
                    for (i = 0; i < used; i++) begin
                        res.out_char = chars[i];
                        res.last     = (i + 1 == used);
                        res.count    = used[4:0];
                        owed_results.push_back(res);
                    end
                    return;
                end
            end
            default: begin
                // spare op codes leave the list alone
            end
        endcase
        res.count = used[4:0];
        owed_results.push_back(res);
    endtask

    // compare one result transaction with the oldest owed result
    task automatic compare_result(input out_item_t got);
        out_item_t want;
        checked++;
        if (owed_results.size() == 0) begin
            report_mismatch($sformatf("result %h with none owed", got));
            return;
        end
        want = owed_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, owed %0d", got.status, want.status));
        if (got.out_char !== want.out_char)
            report_mismatch($sformatf("out_char %h, owed %h", got.out_char, want.out_char));
        if (got.last !== want.last)
            report_mismatch($sformatf("last %b, owed %b", got.last, want.last));
        if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, owed %0d", got.count, want.count));
    endtask

    // results first, so a new command never covers for a result with none owed
    always @(posedge aclk) begin
        if (!aresetn) begin
            used = 0;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) compare_result(m_data);
            if (s_valid && s_ready) apply_command(s_data);
        end
        pending = owed_results.size();
    end

endmodule

@@ tb/testbench.sv @@
// top of the ordered char list engine testbench: clock, reset, command stimulus and verdict
// depends on olce_pkg, ordered_char_list_engine_core and olce_result_checker
module testbench;
    import olce_pkg::*;

    // op codes the block leaves undefined
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_COMMANDS = 500;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;

    typedef enum int {GROW, SHRINK, MIXED} drift_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int fail_count;
    int pending;
    int checked;
    int cycles = 0;
    int sent   = 0;
    int dumps  = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;

    // a few characters that recur so removes hit and duplicates appear
    logic [7:0] favorites [6] = '{8'h00, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h7F};

    always #2 aclk = ~aclk;

    ordered_char_list_engine_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    olce_result_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // present one command transaction and hold it until accepted
    task automatic issue_command(input logic [2:0] cmd_op, input logic [7:0] cmd_key);
        int gap;
        bit taken;
        gap = src_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{cmd_op, cmd_key};
        // ready is settled at the falling edge, so it decides the next rising edge
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        sent++;
        if (cmd_op == OP_DUMP) dumps++;
    endtask

    // weighted op choice that lets the list drift toward full or empty
    function automatic logic [2:0] pick_command(input drift_t drift);
        int roll;
        int push_w;
        int pop_w;
        roll   = $urandom_range(0, 99);
        push_w = (drift == GROW) ? 70 : (drift == SHRINK) ? 15 : 40;
        pop_w  = (drift == GROW) ? 10 : (drift == SHRINK) ? 65 : 40;
        if (roll < push_w)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (roll < push_w + pop_w)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (roll < push_w + pop_w + 12)
            return OP_REMOVE;
        if (roll < push_w + pop_w + 18)
            return OP_DUMP;
        return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    endfunction

    // result side: random stalls with stretches of none
    initial begin : result_sink
        int gap;
        bit taken;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do begin
                @(negedge aclk);
                taken = m_valid;
                @(posedge aclk);
            end while (!taken);
        end
    end

    initial begin : stimulus
        int     n;
        int     directed;
        drift_t drift;
        logic [2:0] op_pick;
        logic [7:0] key_pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // error paths on an empty list
        issue_command(OP_DUMP, 8'h00);
        issue_command(OP_POP_FRONT, 8'h00);
        issue_command(OP_POP_BACK, 8'hFF);
        issue_command(OP_REMOVE, 8'h41);
        issue_command(OP_SPARE_6, 8'hA5);
        // pop back of a single element empties the list
        issue_command(OP_PUSH_BACK, 8'hFF);
        issue_command(OP_POP_BACK, 8'h00);
        issue_command(OP_SPARE_7, 8'h5A);
        // fill to capacity from both ends, keys 00 up to FF
        for (n = 0; n < 16; n++) begin
            issue_command(n[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, 8'(n * 17));
        end
        issue_command(OP_PUSH_FRONT, 8'h5A);
        issue_command(OP_PUSH_BACK, 8'hA5);
        issue_command(OP_DUMP, 8'h00);
        issue_command(OP_REMOVE, 8'h01);
        issue_command(OP_REMOVE, 8'h88);
        issue_command(OP_POP_FRONT, 8'h00);
        issue_command(OP_DUMP, 8'hFF);
        directed = sent;

        // random commands, drifting between growth and shrinkage
        drift = GROW;
        for (n = 0; n < RANDOM_COMMANDS; n++) begin
            if ($urandom_range(0, 29) == 0) drift = drift_t'($urandom_range(0, 2));
            if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
            op_pick  = pick_command(drift);
            key_pick = $urandom_range(0, 1) ? favorites[$urandom_range(0, 5)]
                                            : 8'($urandom_range(0, 255));
            issue_command(op_pick, key_pick);
        end
        s_valid <= 1'b0;

        // wait for every owed result, then watch a while for strays
        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d commands (%0d directed, %0d dumps)", sent, directed, dumps);
        $display("%0d result transactions checked, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
